FILE: rtl/core/egcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned GCD_WIDTH     = OPERAND_WIDTH - 1;
  localparam int unsigned CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } egcd_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/egcd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface egcd_in_if;
  import egcd_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [OPERAND_WIDTH-1:0] value_a;
  logic signed [OPERAND_WIDTH-1:0] value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/egcd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface egcd_out_if;
  import egcd_pkg::*;

  logic                            valid;
  logic                            ready;
  logic        [GCD_WIDTH-1:0]     divisor;
  logic signed [OPERAND_WIDTH-1:0] coef_a;
  logic signed [OPERAND_WIDTH-1:0] coef_b;

  modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
  modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/extended_gcd_unit.sv
// Extended Euclidean unit: for signed operands a and b it returns g = gcd(|a|, |b|)
// and coefficients x, y with a*x + b*y = g, all reduced to the port widths.
// Channels: in_i (sink) carries value_a and value_b; out_o (source) carries
// divisor, coef_a and coef_b. A transaction completes when valid and ready are high.
// One transaction is in work at a time; in_i.ready is high only while the unit is idle.
// Each Euclid step runs a restoring divider that retires one quotient bit per cycle
// and builds q*s and q*t alongside.
// An operand pair with b equal to zero runs no Euclid step and goes from the
// step loop straight to the final state.
// Results sit in an output register, so a new transaction is accepted while the
// previous result still waits. If the receiver stalls, the next finished result
// waits in the final state until the output register frees up.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module extended_gcd_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  egcd_in_if.sink    in_i,
  egcd_out_if.source out_o
);
  import egcd_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  egcd_state_e state_q, state_d;

  logic [W-1:0]         r_prev_mag_q, r_cur_mag_q;
  logic                 r_prev_neg_q, r_cur_neg_q;
  logic [W-1:0]         s_prev_q, s_cur_q, t_prev_q, t_cur_q;
  logic [W-1:0]         rem_q, quo_q, ps_q, pt_q;
  logic [CNT_WIDTH-1:0] cnt_q;

  logic                 out_valid_q;
  logic [GCD_WIDTH-1:0] divisor_q;
  logic [W-1:0]         coef_a_q, coef_b_q;

  logic                 in_accept;
  logic                 load_out;
  logic [W-1:0]         a_raw, b_raw, a_mag, b_mag;
  logic [W-1:0]         shifted;
  logic [W:0]           trial;
  logic                 qbit;
  logic                 q_neg;
  logic                 res_neg;
  logic                 div_last;

  assign a_raw = in_i.value_a;
  assign b_raw = in_i.value_b;
  assign a_mag = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
  assign b_mag = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;

  assign shifted  = {rem_q[W-2:0], quo_q[W-1]};
  assign trial    = {1'b0, shifted} - {1'b0, r_cur_mag_q};
  assign qbit     = ~trial[W];
  assign q_neg    = r_prev_neg_q ^ r_cur_neg_q;
  assign res_neg  = r_prev_neg_q && (r_prev_mag_q != '0);
  assign div_last = (cnt_q == CNT_WIDTH'(W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_LOOP;
      end
      ST_LOOP: begin
        state_d = (r_cur_mag_q == '0) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_LOOP;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_i.ready = 1'b1;
      ST_FINISH: load_out   = !out_valid_q || out_o.ready;
      default: begin
        in_i.ready = 1'b0;
        load_out   = 1'b0;
      end
    endcase
  end

  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          r_prev_mag_q <= a_mag;
          r_prev_neg_q <= a_raw[W-1];
          r_cur_mag_q  <= b_mag;
          r_cur_neg_q  <= b_raw[W-1];
          s_prev_q     <= W'(1);
          s_cur_q      <= '0;
          t_prev_q     <= '0;
          t_cur_q      <= W'(1);
        end
      end
      ST_LOOP: begin
        rem_q <= '0;
        quo_q <= r_prev_mag_q;
        ps_q  <= '0;
        pt_q  <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? trial[W-1:0] : shifted;
        quo_q <= {quo_q[W-2:0], qbit};
        ps_q  <= {ps_q[W-2:0], 1'b0} + (qbit ? s_cur_q : '0);
        pt_q  <= {pt_q[W-2:0], 1'b0} + (qbit ? t_cur_q : '0);
        cnt_q <= cnt_q + CNT_WIDTH'(1);
      end
      ST_UPDATE: begin
        r_prev_mag_q <= r_cur_mag_q;
        r_prev_neg_q <= r_cur_neg_q;
        r_cur_mag_q  <= rem_q;
        r_cur_neg_q  <= r_prev_neg_q;
        s_prev_q     <= s_cur_q;
        s_cur_q      <= q_neg ? (s_prev_q + ps_q) : (s_prev_q - ps_q);
        t_prev_q     <= t_cur_q;
        t_cur_q      <= q_neg ? (t_prev_q + pt_q) : (t_prev_q - pt_q);
      end
      ST_FINISH: begin
        if (load_out) begin
          divisor_q <= r_prev_mag_q[GCD_WIDTH-1:0];
          coef_a_q  <= res_neg ? (W'(0) - s_prev_q) : s_prev_q;
          coef_b_q  <= res_neg ? (W'(0) - t_prev_q) : t_prev_q;
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.divisor = divisor_q;
  assign out_o.coef_a  = coef_a_q;
  assign out_o.coef_b  = coef_b_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_LOOP))
    else $error("accepted transaction did not start the step loop");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (r_cur_mag_q != '0))
    else $error("divider running with a zero divisor");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && !div_last) |=> (state_q == ST_DIV))
    else $error("divider left before all quotient bits were retired");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (rem_q < r_cur_mag_q))
    else $error("remainder not below divisor after division");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_o.valid)
    else $error("loaded result not presented on the output");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

import egcd_pkg::*;

typedef struct packed {
  logic        [GCD_WIDTH-1:0]     divisor;
  logic signed [OPERAND_WIDTH-1:0] coef_a;
  logic signed [OPERAND_WIDTH-1:0] coef_b;
} bezout_t;

class bezout_checker;
  localparam int StepLimit = 2 * OPERAND_WIDTH + 4;

  bezout_t pending_bezout[$];
  int      mismatch_count = 0;

  function automatic bezout_t bezout_of(logic signed [OPERAND_WIDTH-1:0] a,
                                        logic signed [OPERAND_WIDTH-1:0] b);
    longint  r_old, r_new, quot, rem;
    longint  s_old, s_new, t_old, t_new, s_next, t_next;
    int      steps;
    bezout_t res;
    r_old = a;
    r_new = b;
    s_old = 1;
    s_new = 0;
    t_old = 0;
    t_new = 1;
    steps = 0;
    while (r_new != 0 && steps < StepLimit) begin
      quot   = r_old / r_new;
      rem    = r_old % r_new;
      s_next = s_old - quot * s_new;
      t_next = t_old - quot * t_new;
      r_old  = r_new;
      r_new  = rem;
      s_old  = s_new;
      s_new  = s_next;
      t_old  = t_new;
      t_new  = t_next;
      steps++;
    end
    if (r_old < 0) begin
      r_old = -r_old;
      s_old = -s_old;
      t_old = -t_old;
    end
    res.divisor = r_old[GCD_WIDTH-1:0];
    res.coef_a  = s_old[OPERAND_WIDTH-1:0];
    res.coef_b  = t_old[OPERAND_WIDTH-1:0];
    return res;
  endfunction

  function void note_operands(logic signed [OPERAND_WIDTH-1:0] a,
                              logic signed [OPERAND_WIDTH-1:0] b);
    pending_bezout = {pending_bezout, bezout_of(a, b)};
  endfunction

  function void check_result(logic [GCD_WIDTH-1:0] divisor,
                             logic signed [OPERAND_WIDTH-1:0] coef_a,
                             logic signed [OPERAND_WIDTH-1:0] coef_b);
    bezout_t want;
    if (pending_bezout.size() == 0) begin
      $display("%0t: unexpected result divisor %0d coef_a %0d coef_b %0d",
               $time, divisor, coef_a, coef_b);
      mismatch_count++;
      return;
    end
    want = pending_bezout.pop_front();
    if (divisor !== want.divisor) begin
      $display("%0t: divisor expected %0d actual %0d", $time, want.divisor, divisor);
      mismatch_count++;
    end
    if (coef_a !== want.coef_a) begin
      $display("%0t: coef_a expected %0d actual %0d", $time, want.coef_a, coef_a);
      mismatch_count++;
    end
    if (coef_b !== want.coef_b) begin
      $display("%0t: coef_b expected %0d actual %0d", $time, want.coef_b, coef_b);
      mismatch_count++;
    end
  endfunction

  function int outstanding();
    return pending_bezout.size();
  endfunction
endclass

module tb;
  localparam int RandomItems = 1550;
  localparam int MaxMag      = 2147483647;

  logic clk;
  logic rst_n;

  egcd_in_if  in_if ();
  egcd_out_if out_if ();

  extended_gcd_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bezout_checker checker_h = new();

  int tx_idle_pct = 15;
  int rx_idle_pct = 65;
  int results_seen = 0;
  bit hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #250_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_operands(input logic signed [OPERAND_WIDTH-1:0] a,
                               input logic signed [OPERAND_WIDTH-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.value_a <= a;
    in_if.value_b <= b;
    do @(posedge clk); while (!in_if.ready);
    checker_h.note_operands(a, b);
    @(negedge clk);
  endtask

  function automatic logic signed [OPERAND_WIDTH-1:0] random_operand();
    int unsigned bits;
    int unsigned mag;
    if ($urandom_range(99) < 80) begin
      bits = $urandom_range(10, 1);
    end else begin
      bits = 31;
    end
    mag = $urandom & ((32'h1 << bits) - 1);
    if (bits == 31) mag = mag & 32'h7fff_ffff;
    if ($urandom_range(1)) return -$signed(mag);
    return $signed(mag);
  endfunction

  task automatic send_random();
    int unsigned sel;
    int unsigned g;
    int unsigned m;
    int unsigned n;
    logic signed [OPERAND_WIDTH-1:0] a;
    logic signed [OPERAND_WIDTH-1:0] b;
    sel = $urandom_range(99);
    a = random_operand();
    b = random_operand();
    if (sel < 5) begin
      b = '0;
    end else if (sel < 8) begin
      a = '0;
    end else if (sel < 18) begin
      g = $urandom_range(32767, 1);
      m = $urandom_range(32767);
      n = $urandom_range(32767);
      a = $signed(g * m);
      b = $signed(g * n);
      if ($urandom_range(1)) a = -a;
      if ($urandom_range(1)) b = -b;
    end
    send_operands(a, b);
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.value_a <= '0;
    in_if.value_b <= '0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    send_operands(0, 0);
    send_operands(5, 0);
    send_operands(-5, 0);
    send_operands(MaxMag, 0);
    send_operands(-MaxMag, 0);
    send_operands(0, 7);
    send_operands(0, -7);
    send_operands(1, 1);
    send_operands(-1, -1);
    send_operands(MaxMag, MaxMag);
    send_operands(MaxMag, -MaxMag);
    send_operands(-MaxMag, 1);
    send_operands(1, -MaxMag);
    send_operands(MaxMag, MaxMag - 1);
    send_operands(1836311903, 1134903170);
    send_operands(-1836311903, 1134903170);
    send_operands(1134903170, -1836311903);
    send_operands(12, 18);
    send_operands(-12, 18);
    send_operands(12, -18);
    send_operands(-12, -18);
    send_operands(32'sh5555_5555, 32'sh2aaa_aaaa);
    send_operands(-32'sh2aaa_aaab, 32'sh7fff_fffe);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 15;
      end else if (i == 2 * RandomItems / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random();
    end
    in_if.valid <= 1'b0;

    while (checker_h.outstanding() != 0) @(posedge clk);
    repeat (1600) @(posedge clk);
    if (checker_h.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen == 200) begin
        hold_done = 1;
        out_if.ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        checker_h.check_result(out_if.divisor, out_if.coef_a, out_if.coef_b);
        results_seen++;
      end
    end
  end
endmodule

FILE: files.f
rtl/core/egcd_pkg.sv
rtl/core/egcd_in_if.sv
rtl/core/egcd_out_if.sv
rtl/core/extended_gcd_unit.sv
tb/tb.sv
